### design/pws_pkg.sv
// shared constants, types and helper functions of the phase-to-waveform shaper
package pws_pkg;

    // phase and sample formats
    localparam int PHASE_BITS       = 12;
    localparam int SAMPLE_FRAC_BITS = 14;
    localparam int SAMPLE_W         = 16;
    localparam int OP_W             = 2;

    // phase landmarks
    localparam int QUARTER   = 1 << (PHASE_BITS - 2);
    localparam int ADDR_W    = PHASE_BITS - 1;
    localparam int ROM_W     = SAMPLE_FRAC_BITS + 1;

    // signed working width for triangle and saw numerators
    localparam int NUM_W     = PHASE_BITS + 4;
    localparam int SCALED_W  = NUM_W + SAMPLE_FRAC_BITS;

    // pi with 60 fraction bits, truncated
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // waveform select codes
    localparam logic [OP_W-1:0] OP_SINE     = 2'd0;
    localparam logic [OP_W-1:0] OP_TRIANGLE = 2'd1;
    localparam logic [OP_W-1:0] OP_SAW      = 2'd2;
    localparam logic [OP_W-1:0] OP_SQUARE   = 2'd3;

    typedef logic [ROM_W-1:0] sine_rom_t [0:QUARTER];

    // quarter-wave table, built at elaboration from a truncated taylor series
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] rounded;
        logic [127:0] prod;
        logic        neg;
        logic        done;
        for (int r = 0; r <= QUARTER; r++)
        begin
            x    = (PI_Q60 >> (PHASE_BITS - 2)) * 64'(r);
            prod = {64'd0, x} * {64'd0, x};
            x2   = prod[124:61];
            term = x;
            sum  = x;
            neg  = 1'b1;
            done = 1'b0;
            for (int k = 2; k < 48; k += 2)
            begin
                if (!done)
                begin
                    prod = {64'd0, term} * {64'd0, x2};
                    term = prod[124:61] / 64'(k * (k + 1));
                    if (term == 64'd0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        if (neg)
                        begin
                            sum = sum - term;
                        end
                        else
                        begin
                            sum = sum + term;
                        end
                        neg = !neg;
                    end
                end
            end
            rounded = (sum + (64'd1 << (60 - SAMPLE_FRAC_BITS))) >> (61 - SAMPLE_FRAC_BITS);
            rom[r]  = rounded[ROM_W-1:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // num * 2^F / 2^P, rounded to nearest with ties away from zero
    function automatic logic [SAMPLE_W-1:0] scale_round(input logic signed [NUM_W-1:0] num);
        logic                neg;
        logic [NUM_W-1:0]    mag;
        logic [SCALED_W-1:0] scaled;
        logic [SCALED_W-1:0] res;
        neg    = num[NUM_W-1];
        mag    = neg ? (~num + NUM_W'(1)) : num;
        scaled = {mag, {SAMPLE_FRAC_BITS{1'b0}}} + (SCALED_W'(1) << (PHASE_BITS - 1));
        res    = scaled >> PHASE_BITS;
        if (neg)
        begin
            res = ~res + SCALED_W'(1);
        end
        return res[SAMPLE_W-1:0];
    endfunction

endpackage

### design/phase_to_waveform_shaper.sv
// phase-to-waveform shaper: sine, triangle, saw and square from a phase fraction
//
// Takes one beat per clock (op and phase) unless stalled, and returns one signed Q2.14
// sample per beat. The first stage registers the quarter-wave table read together with
// the triangle, saw and square value, the second applies the sine quadrant sign and
// registers the sample. The 1025-entry quarter-wave table has a single read port.
// A stage holds its beat only while the stage after it is full, so while a finished
// sample waits the input side takes one more beat and then stalls until the sample is
// taken.
// The block holds no configuration and no state beyond the pipeline.
module phase_to_waveform_shaper
    import pws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] op, [13:2] phase, [15:14] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] sample
);

    localparam int SINE_EXT_W = SAMPLE_FRAC_BITS + SAMPLE_W;

    // input fields
    logic [OP_W-1:0]       in_op;
    logic [PHASE_BITS-1:0] in_phase;
    assign in_op    = s_tdata[OP_W-1:0];
    assign in_phase = s_tdata[OP_W+PHASE_BITS-1:OP_W];

    // stage enables
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_en;
    logic s1_en;
    assign out_en   = !out_valid_reg || m_tready;
    assign s1_en    = !s1_valid_reg || out_en;
    assign s_tready = s1_en;

    // quarter-wave address, mirrored in odd quadrants
    logic [1:0]          quad;
    logic [ADDR_W-1:0]   rel;
    logic [ADDR_W-1:0]   rom_addr;
    assign quad     = in_phase[PHASE_BITS-1:PHASE_BITS-2];
    assign rel      = ADDR_W'(in_phase[PHASE_BITS-3:0]);
    assign rom_addr = quad[0] ? (ADDR_W'(QUARTER) - rel) : rel;

    // triangle, saw and square
    logic                    first_half;
    logic signed [NUM_W-1:0] p_ext;
    logic signed [NUM_W-1:0] full_ext;
    logic signed [NUM_W-1:0] tri_num;
    logic signed [NUM_W-1:0] saw_num;
    logic [SINE_EXT_W-1:0]   one_ext;
    logic [SAMPLE_W-1:0]     alt_next;
    assign first_half = in_phase <= PHASE_BITS'(1 << (PHASE_BITS - 1));
    assign p_ext      = NUM_W'(in_phase);
    assign full_ext   = NUM_W'(1) << PHASE_BITS;
    assign tri_num    = first_half ? ((p_ext <<< 2) - full_ext)
                                   : ((full_ext <<< 1) + full_ext - (p_ext <<< 2));
    assign saw_num    = (p_ext <<< 1) - full_ext;
    assign one_ext    = SINE_EXT_W'(1) << SAMPLE_FRAC_BITS;

    always_comb
    begin
        case (in_op)
            OP_TRIANGLE: alt_next = scale_round(tri_num);
            OP_SAW:      alt_next = scale_round(saw_num);
            OP_SQUARE:
            begin
                if (first_half)
                begin
                    alt_next = one_ext[SAMPLE_W-1:0];
                end
                else
                begin
                    alt_next = SAMPLE_W'(~one_ext + SINE_EXT_W'(1));
                end
            end
            default:     alt_next = '0;
        endcase
    end

    // stage 1 registers
    logic [ROM_W-1:0]    rom_data_reg;
    logic [OP_W-1:0]     s1_op_reg;
    logic                s1_neg_reg;
    logic [SAMPLE_W-1:0] s1_alt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && s_tvalid)
        begin
            rom_data_reg <= SINE_ROM[rom_addr];
            s1_op_reg    <= in_op;
            s1_neg_reg   <= quad[1];
            s1_alt_reg   <= alt_next;
        end
    end

    // sine sign and final select
    logic [SINE_EXT_W-1:0] sine_ext;
    logic [SINE_EXT_W-1:0] sine_signed;
    logic [SAMPLE_W-1:0]   sample_next;
    assign sine_ext    = SINE_EXT_W'(rom_data_reg);
    assign sine_signed = s1_neg_reg ? (~sine_ext + SINE_EXT_W'(1)) : sine_ext;
    assign sample_next = (s1_op_reg == OP_SINE) ? sine_signed[SAMPLE_W-1:0] : s1_alt_reg;

    // output register
    logic [SAMPLE_W-1:0] sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && s1_valid_reg)
        begin
            sample_reg <= sample_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sample_reg;

`ifndef SYNTHESIS
    // an empty output stage never holds back the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output stage");

    // a stage-1 beat moves to the output when the output frees up
    a_s1_advances: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_en |=> out_valid_reg)
        else $error("stage-1 beat lost");

    // a blocked stage-1 beat holds its contents
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_en |=> s1_valid_reg && $stable(s1_op_reg)
            && $stable(s1_alt_reg) && $stable(rom_data_reg))
        else $error("stage-1 beat changed while stalled");

    // samples stay within full scale
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($signed(sample_reg) <= $signed(SAMPLE_W'(16384)))
            && ($signed(sample_reg) >= $signed(-SAMPLE_W'(16384))))
        else $error("sample outside full scale");
`endif

endmodule
